// ----- hw/rtl/lfru_pkg.sv -----
// Shared types, codes and constants for the two-list promotion policy engine.
`timescale 1ns / 1ps

package lfru_pkg;

    // Default width of the entry counters
    localparam int COUNT_BITS_DEF = 20;

    localparam int SCORE_W    = 8;
    localparam int WIN_W      = 16;
    localparam int RATIO_W    = 9;
    localparam int FLOOR_W    = 20;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 20;
    localparam int OP_W       = 2;
    localparam int IN_DATA_W  = 16;
    localparam int Q_DEPTH    = 4;

    // Operation codes carried in the input tuser
    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_DEMOTE = 2'd2
    } op_t;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_POLICY_MODE   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SCORE_CAP     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_THRESHOLD = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_SIZE   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_PRIV_RATIO    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_PRIV_FLOOR    = 3'd5;

    typedef struct packed {
        logic               policy_mode;
        logic [SCORE_W-1:0] score_cap;
        logic [SCORE_W-1:0] min_threshold;
        logic [WIN_W-1:0]   window_size;
        logic [RATIO_W-1:0] priv_ratio_256;
        logic [FLOOR_W-1:0] priv_count_floor;
    } cfg_t;

    // Classified command handed from the front end to the back end
    typedef struct packed {
        logic               adapt;      // non-privileged add in frequency mode
        logic               priv_keep;  // privileged add: stays privileged
        logic               unused_inc;
        logic               unused_dec;
        logic               priv_dec;
        logic               removed;
        logic               priv_pass;  // goes_priv unless promoted
        logic               at_cap;     // incremented score sits at the cap
        logic [SCORE_W-1:0] res_score;
    } cmd_t;

endpackage

// ----- hw/rtl/lfru_front.sv -----
// Front end: decode and classify each input item into a command for the queue.
`timescale 1ns / 1ps

module lfru_front
(
    input  lfru_pkg::cfg_t                   cfg,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [lfru_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic [lfru_pkg::OP_W-1:0]        s_axis_tuser,
    input  logic                             q_full,
    output logic                             q_push,
    output lfru_pkg::cmd_t                   q_cmd
);

    logic [lfru_pkg::SCORE_W-1:0] score;
    logic                         is_priv;
    logic                         listed;
    logic                         server;
    logic [lfru_pkg::SCORE_W:0]   score_inc;
    logic [lfru_pkg::SCORE_W-1:0] score_sat;

    assign score   = s_axis_tdata[lfru_pkg::SCORE_W-1:0];
    assign is_priv = s_axis_tdata[lfru_pkg::SCORE_W];
    assign listed  = s_axis_tdata[lfru_pkg::SCORE_W+1];
    assign server  = s_axis_tdata[lfru_pkg::SCORE_W+2];

    assign score_inc = {1'b0, score} + 9'd1;
    assign score_sat = (score_inc > {1'b0, cfg.score_cap}) ? cfg.score_cap
                                                           : score_inc[lfru_pkg::SCORE_W-1:0];

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    always_comb
    begin
        q_cmd           = '0;
        q_cmd.res_score = score;
        q_cmd.priv_pass = is_priv;
        unique case (s_axis_tuser)
            lfru_pkg::OP_ADD:
            begin
                q_cmd.unused_inc = 1'b1;
                q_cmd.priv_pass  = 1'b0;
                if (cfg.policy_mode)
                begin
                    q_cmd.res_score = score_sat;
                    q_cmd.at_cap    = (score_sat == cfg.score_cap);
                    q_cmd.adapt     = !is_priv;
                    q_cmd.priv_keep = is_priv;
                end
            end
            lfru_pkg::OP_REMOVE:
            begin
                q_cmd.unused_dec = listed;
                q_cmd.priv_dec   = listed && cfg.policy_mode && is_priv;
                q_cmd.removed    = listed;
                q_cmd.priv_pass  = 1'b0;
            end
            lfru_pkg::OP_DEMOTE:
            begin
                if (cfg.policy_mode && !server)
                begin
                    q_cmd.unused_dec = listed;
                    q_cmd.priv_dec   = listed && is_priv;
                    q_cmd.removed    = listed;
                    q_cmd.unused_inc = 1'b1;
                    q_cmd.priv_pass  = 1'b0;
                    q_cmd.res_score  = score >> 2;
                end
            end
            default:
            begin
                // no-operation code: pass the entry through untouched
                q_cmd.res_score = score;
            end
        endcase
    end

endmodule

// ----- hw/rtl/lfru_cmd_fifo.sv -----
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module lfru_cmd_fifo
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lfru_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output lfru_pkg::cmd_t head_cmd
);

    localparam int PTR_W = $clog2(lfru_pkg::Q_DEPTH);
    localparam int CNT_W = $clog2(lfru_pkg::Q_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(lfru_pkg::Q_DEPTH);

    lfru_pkg::cmd_t   slot_reg [lfru_pkg::Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == DEPTH_C);
    assign valid    = (count_reg != '0);
    assign head_cmd = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- hw/rtl/lfru_back.sv -----
// Back end: apply commands to the counters and threshold, then form the result.
`timescale 1ns / 1ps

module lfru_back
#(
    parameter  int COUNT_BITS = lfru_pkg::COUNT_BITS_DEF,
    localparam int OUT_W      = ((19 + 2 * COUNT_BITS + 7) / 8) * 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lfru_pkg::cfg_t       cfg,
    input  logic                 q_valid,
    input  lfru_pkg::cmd_t       q_cmd,
    output logic                 q_pop,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_W-1:0]     m_axis_tdata
);

    localparam int CMP_W = (COUNT_BITS > lfru_pkg::FLOOR_W) ? COUNT_BITS : lfru_pkg::FLOOR_W;
    localparam int PROD_W = COUNT_BITS + lfru_pkg::RATIO_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    // Counter and threshold state
    logic [COUNT_BITS-1:0]        unused_reg;
    logic [COUNT_BITS-1:0]        unused_next;
    logic [COUNT_BITS-1:0]        priv_reg;
    logic [COUNT_BITS-1:0]        priv_next;
    logic [lfru_pkg::SCORE_W-1:0] thr_reg;
    logic [lfru_pkg::SCORE_W-1:0] thr_next;
    logic [lfru_pkg::SCORE_W-1:0] wmax_reg;
    logic [lfru_pkg::SCORE_W-1:0] wmax_next;
    logic [lfru_pkg::WIN_W-1:0]   wcnt_reg;
    logic [lfru_pkg::WIN_W-1:0]   wcnt_next;

    // Execute stage
    logic                         s1_valid_reg;
    logic                         s1_valid_next;
    logic [lfru_pkg::SCORE_W-1:0] s1_score_reg;
    logic                         s1_goes_priv_reg;
    logic                         s1_removed_reg;

    // Output stage
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [OUT_W-1:0]             out_data_reg;
    logic [OUT_W-1:0]             out_data_next;

    logic                         s1_ready;
    logic                         s2_ready;
    logic                         s1_load;
    logic                         s2_load;
    logic                         promote;
    logic                         goes_priv;
    logic [COUNT_BITS-1:0]        unused_mid;
    logic [lfru_pkg::SCORE_W-1:0] wmax_seen;
    logic [lfru_pkg::SCORE_W+1:0] wmax_x3;
    logic [lfru_pkg::WIN_W-1:0]   wcnt_inc;
    logic [PROD_W-1:0]            ratio_prod;
    logic [COUNT_BITS:0]          ratio_limit;
    logic                         too_many;

    assign s2_ready = !out_valid_reg || m_axis_tready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign q_pop    = q_valid && s1_ready;
    assign s1_load  = q_pop;
    assign s2_load  = s1_valid_reg && s2_ready;

    assign promote   = q_cmd.adapt && ((q_cmd.res_score > thr_reg) || q_cmd.at_cap);
    assign goes_priv = q_cmd.priv_pass || q_cmd.priv_keep || promote;

    assign wmax_seen = (q_cmd.res_score > wmax_reg) ? q_cmd.res_score : wmax_reg;
    assign wmax_x3   = {2'b00, wmax_seen} + {1'b0, wmax_seen, 1'b0};
    assign wcnt_inc  = wcnt_reg + 1'b1;

    always_comb
    begin
        unused_mid  = (q_cmd.unused_dec && unused_reg != '0) ? unused_reg - 1'b1 : unused_reg;
        unused_next = unused_reg;
        priv_next   = priv_reg;
        thr_next    = thr_reg;
        wmax_next   = wmax_reg;
        wcnt_next   = wcnt_reg;
        if (s1_load)
        begin
            unused_next = (q_cmd.unused_inc && unused_mid != CNT_MAX) ? unused_mid + 1'b1
                                                                      : unused_mid;
            priority if (q_cmd.priv_dec)
            begin
                priv_next = (priv_reg != '0) ? priv_reg - 1'b1 : priv_reg;
            end
            else if (q_cmd.priv_keep || promote)
            begin
                priv_next = (priv_reg != CNT_MAX) ? priv_reg + 1'b1 : priv_reg;
            end
            else
            begin
                priv_next = priv_reg;
            end
            if (q_cmd.adapt)
            begin
                priority if (promote)
                begin
                    thr_next  = q_cmd.res_score;
                    wmax_next = cfg.min_threshold;
                    wcnt_next = '0;
                end
                else if (wcnt_inc == cfg.window_size)
                begin
                    thr_next  = wmax_seen;
                    wmax_next = cfg.min_threshold;
                    wcnt_next = '0;
                end
                else if (wcnt_inc == (cfg.window_size >> 1))
                begin
                    // decay the running maximum to three quarters at half-window
                    wmax_next = wmax_x3[lfru_pkg::SCORE_W+1:2];
                    wcnt_next = wcnt_inc;
                end
                else
                begin
                    wmax_next = wmax_seen;
                    wcnt_next = wcnt_inc;
                end
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_load ? 1'b1 : (s2_load ? 1'b0 : s1_valid_reg);
        out_valid_next = s2_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
    end

    // Ratio limit from the counts left by the item in the execute stage
    assign ratio_prod  = PROD_W'(unused_reg) * PROD_W'(cfg.priv_ratio_256);
    assign ratio_limit = ratio_prod[PROD_W-1:8];
    assign too_many    = (CMP_W'(priv_reg) >= CMP_W'(cfg.priv_count_floor))
                         && ({1'b0, priv_reg} >= ratio_limit);
    assign out_data_next = OUT_W'({priv_reg, unused_reg, thr_reg, too_many,
                                   s1_removed_reg, s1_goes_priv_reg, s1_score_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unused_reg    <= '0;
            priv_reg      <= '0;
            thr_reg       <= '0;
            wmax_reg      <= '0;
            wcnt_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unused_reg    <= unused_next;
            priv_reg      <= priv_next;
            thr_reg       <= thr_next;
            wmax_reg      <= wmax_next;
            wcnt_reg      <= wcnt_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_score_reg     <= q_cmd.res_score;
            s1_goes_priv_reg <= goes_priv;
            s1_removed_reg   <= q_cmd.removed;
        end
        if (s2_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_counts_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_load |=> $stable(unused_reg) && $stable(priv_reg))
        else $error("counts moved without a command");

    a_thr_only_on_adapt: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_load && !q_cmd.adapt) |=> $stable(thr_reg) && $stable(wcnt_reg))
        else $error("threshold window moved on a command that does not adapt");

    a_net_add_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_load && q_cmd.unused_inc) |=> (unused_reg != '0))
        else $error("unused count zero after an add");

    a_removed_not_priv: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_load && q_cmd.removed) |=> !s1_goes_priv_reg)
        else $error("removed entry marked privileged");

endmodule

// ----- hw/rtl/lfru_promotion_policy.sv -----
// Top level of the two-list promotion policy engine: config registers and wiring.
`timescale 1ns / 1ps

// Decision engine for a privileged/normal two-list replacement policy. Each input
// item (add, remove or demote of one entry) yields exactly one result item with the
// entry's new score, its list, whether it left a list, the too-many-privileged flag,
// the current promotion threshold and both counts as they stand after that item.
// Sustained rate is one item per clock unless the output stalls, bounded by the
// counter, window maximum and threshold update done as each command is popped.
// With an empty queue an accepted item passes through the queue slot and the
// execute stage register, after which the output register, loaded with the
// ratio multiply and compare, drives the result. A four-entry command queue
// decouples the input from the back end, so input keeps flowing while a result
// waits on the output. Write configuration only while the block is idle.

module lfru_promotion_policy
#(
    parameter  int COUNT_BITS = lfru_pkg::COUNT_BITS_DEF,
    localparam int OUT_W      = ((19 + 2 * COUNT_BITS + 7) / 8) * 8
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [lfru_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [lfru_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // input items
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // entry_score[7:0], entry_is_priv[8], entry_listed[9], entry_server_side[10]
    input  logic [lfru_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // operation[1:0]
    input  logic [lfru_pkg::OP_W-1:0]           s_axis_tuser,
    // result items
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // new_score, goes_priv, was_removed, priv_too_many, current_threshold (8),
    // unused_total (COUNT_BITS), priv_total (COUNT_BITS), zero padded
    output logic [OUT_W-1:0]                    m_axis_tdata
);

    lfru_pkg::cfg_t cfg_reg;
    lfru_pkg::cfg_t cfg_next;
    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_valid;
    lfru_pkg::cmd_t push_cmd;
    lfru_pkg::cmd_t head_cmd;

    // Register writes; indexes beyond the list are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                lfru_pkg::REG_POLICY_MODE:   cfg_next.policy_mode      = cfg_wdata[0];
                lfru_pkg::REG_SCORE_CAP:     cfg_next.score_cap        = cfg_wdata[7:0];
                lfru_pkg::REG_MIN_THRESHOLD: cfg_next.min_threshold    = cfg_wdata[7:0];
                lfru_pkg::REG_WINDOW_SIZE:   cfg_next.window_size      = cfg_wdata[15:0];
                lfru_pkg::REG_PRIV_RATIO:    cfg_next.priv_ratio_256   = cfg_wdata[8:0];
                lfru_pkg::REG_PRIV_FLOOR:    cfg_next.priv_count_floor = cfg_wdata[19:0];
                default:                     cfg_next                  = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.policy_mode      <= 1'b1;
            cfg_reg.score_cap        <= 8'd255;
            cfg_reg.min_threshold    <= 8'd1;
            cfg_reg.window_size      <= 16'd256;
            cfg_reg.priv_ratio_256   <= 9'd85;
            cfg_reg.priv_count_floor <= 20'd100;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Classify items as they arrive
    lfru_front u_front
    (
        .cfg           (cfg_reg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (push_cmd)
    );

    // Hold classified commands until the back end takes them
    lfru_cmd_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head_cmd (head_cmd)
    );

    // Advance the counters and threshold, then drive results
    lfru_back #(.COUNT_BITS(COUNT_BITS)) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_cmd         (head_cmd),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ----- tb/sv/lfru_promotion_policy_tb.sv -----
// Self-checking testbench for the two-list promotion policy engine.
`timescale 1ns / 1ps

module lfru_promotion_policy_tb;

    import lfru_pkg::*;

    localparam int CB              = COUNT_BITS_DEF;
    localparam int OUT_W           = ((19 + 2 * CB + 7) / 8) * 8;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 94;

    // Operation code outside the enum: the block must pass the entry through untouched
    localparam logic [OP_W-1:0] OP_NOP = 2'd3;

    // One result item, last field in the lowest bits as on m_axis_tdata
    typedef struct packed {
        logic [CB-1:0]      priv_total;
        logic [CB-1:0]      unused_total;
        logic [SCORE_W-1:0] threshold;
        logic               too_many;
        logic               was_removed;
        logic               goes_priv;
        logic [SCORE_W-1:0] new_score;
    } policy_result_t;

    localparam int RES_W = $bits(policy_result_t);

    // One row of the directed table: either a register write or an item,
    // the latter with an optional hand-typed result
    typedef struct packed {
        logic                  is_write;
        logic [CFG_ADDR_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [OP_W-1:0]       op;
        logic [SCORE_W-1:0]    score;
        logic                  is_priv;
        logic                  listed;
        logic                  server;
        logic                  has_exp;
        policy_result_t        want;
    } stim_row_t;

    typedef struct packed {
        logic               mode;
        logic [SCORE_W-1:0] cap;
        logic [SCORE_W-1:0] min_thr;
        logic [WIN_W-1:0]   win;
        logic [RATIO_W-1:0] ratio;
        logic [FLOOR_W-1:0] floor_val;
    } settings_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // entry_score[7:0], entry_is_priv[8], entry_listed[9], entry_server_side[10]
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    // operation[1:0]
    logic [OP_W-1:0]       s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // new_score[7:0], goes_priv[8], was_removed[9], priv_too_many[10],
    // current_threshold[18:11], unused_total[38:19], priv_total[58:39], zeros above
    logic [OUT_W-1:0]      m_axis_tdata;

    // Mirror of the configuration registers, at their reset values
    logic                  mode_cfg    = 1'b1;
    logic [SCORE_W-1:0]    cap_cfg     = 8'd255;
    logic [SCORE_W-1:0]    min_thr_cfg = 8'd1;
    logic [WIN_W-1:0]      win_cfg     = 16'd256;
    logic [RATIO_W-1:0]    ratio_cfg   = 9'd85;
    logic [FLOOR_W-1:0]    floor_cfg   = 20'd100;

    // Mirror of the policy state, all zero after reset
    logic [CB-1:0]         unused_cnt  = '0;
    logic [CB-1:0]         priv_cnt    = '0;
    logic [SCORE_W-1:0]    thr         = '0;
    logic [SCORE_W-1:0]    win_max     = '0;
    logic [WIN_W-1:0]      win_cnt     = '0;

    // Results still owed by the block, oldest first
    policy_result_t        pending_results [$];
    int                    errors;
    // Hand-typed result for the item currently offered, if any
    logic                  row_has_exp;
    policy_result_t        row_exp;
    // Suppress idling on both sides while set
    bit                    calm;

    lfru_promotion_policy #(
        .COUNT_BITS (CB)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the block hangs or drops an item
    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Counts saturate at the top and stop at zero
    function automatic logic [CB-1:0] count_up(logic [CB-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [CB-1:0] count_down(logic [CB-1:0] v);
        return (v == '0) ? v : v - 1'b1;
    endfunction

    // Track the window maximum and move the promotion threshold.
    // The full-window test wins over the half-window decay.
    function automatic void adapt_threshold(logic [SCORE_W-1:0] s);
        if (s > thr || s == cap_cfg)
        begin
            thr     = s;
            win_max = min_thr_cfg;
            win_cnt = '0;
            return;
        end
        if (s > win_max)
            win_max = s;
        win_cnt = win_cnt + 1'b1;
        if (win_cnt == win_cfg)
        begin
            thr     = win_max;
            win_max = min_thr_cfg;
            win_cnt = '0;
        end
        else if (win_cnt == (win_cfg >> 1))
        begin
            win_max = 8'((10'(win_max) * 10'd3) / 10'd4);
        end
    endfunction

    // Take a listed entry off its list; the privileged count only moves in LFRU mode
    function automatic logic leave_list(logic listed, logic is_priv);
        if (!listed)
            return 1'b0;
        unused_cnt = count_down(unused_cnt);
        if (mode_cfg && is_priv)
            priv_cnt = count_down(priv_cnt);
        return 1'b1;
    endfunction

    // Advance the mirrored state by one item and return the result it should produce
    function automatic policy_result_t apply_policy_op(logic [OP_W-1:0] op,
                                                       logic [SCORE_W-1:0] score,
                                                       logic is_priv, logic listed,
                                                       logic server);
        policy_result_t r;
        logic [SCORE_W:0] bumped;
        logic [63:0]      ratio_limit;
        r           = '0;
        r.new_score = score;
        r.goes_priv = is_priv;
        if (op == OP_ADD)
        begin
            unused_cnt  = count_up(unused_cnt);
            r.goes_priv = 1'b0;
            if (mode_cfg)
            begin
                bumped = {1'b0, score} + 1'b1;
                if (bumped > {1'b0, cap_cfg})
                    bumped = {1'b0, cap_cfg};
                r.new_score = bumped[SCORE_W-1:0];
                // privileged entries stay; others promote above threshold or at the cap
                if (is_priv || r.new_score > thr || r.new_score == cap_cfg)
                begin
                    priv_cnt    = count_up(priv_cnt);
                    r.goes_priv = 1'b1;
                end
                if (!is_priv)
                    adapt_threshold(r.new_score);
            end
        end
        else if (op == OP_REMOVE)
        begin
            r.was_removed = leave_list(listed, is_priv);
            r.goes_priv   = 1'b0;
        end
        else if (op == OP_DEMOTE && mode_cfg && !server)
        begin
            r.was_removed = leave_list(listed, is_priv);
            unused_cnt    = count_up(unused_cnt);
            r.goes_priv   = 1'b0;
            r.new_score   = score >> 2;
        end
        // a no-op, an LRU demote or a server-side demote falls through with the entry unchanged
        ratio_limit    = (64'(unused_cnt) * 64'(ratio_cfg)) >> 8;
        r.too_many     = (priv_cnt >= floor_cfg) && (64'(priv_cnt) >= ratio_limit);
        r.threshold    = thr;
        r.unused_total = unused_cnt;
        r.priv_total   = priv_cnt;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: everything that happens at a rising edge is handled here,
    // results first, so nothing hangs on the order of processes
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        policy_result_t got;
        policy_result_t want;
        if (rst_n)
        begin
            // compare each result item with the oldest outstanding expectation
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = policy_result_t'(m_axis_tdata[RES_W-1:0]);
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: result item with nothing expected, tdata 0x%0h",
                             $time, m_axis_tdata);
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("new_score", want.new_score, got.new_score);
                    check_field("goes_priv", want.goes_priv, got.goes_priv);
                    check_field("was_removed", want.was_removed, got.was_removed);
                    check_field("priv_too_many", want.too_many, got.too_many);
                    check_field("current_threshold", want.threshold, got.threshold);
                    check_field("unused_total", want.unused_total, got.unused_total);
                    check_field("priv_total", want.priv_total, got.priv_total);
                    check_field("tdata padding", 0, m_axis_tdata[OUT_W-1:RES_W]);
                end
            end

            // track register writes in the mirror
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    REG_POLICY_MODE:   mode_cfg    = cfg_wdata[0];
                    REG_SCORE_CAP:     cap_cfg     = cfg_wdata[SCORE_W-1:0];
                    REG_MIN_THRESHOLD: min_thr_cfg = cfg_wdata[SCORE_W-1:0];
                    REG_WINDOW_SIZE:   win_cfg     = cfg_wdata[WIN_W-1:0];
                    REG_PRIV_RATIO:    ratio_cfg   = cfg_wdata[RATIO_W-1:0];
                    REG_PRIV_FLOOR:    floor_cfg   = cfg_wdata[FLOOR_W-1:0];
                    default: ;
                endcase
            end

            // predict from the bits actually on the bus
            if (s_axis_tvalid && s_axis_tready)
            begin
                want = apply_policy_op(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[8],
                                       s_axis_tdata[9], s_axis_tdata[10]);
                // a hand-typed result overrides the prediction; the mirror still advances
                if (row_has_exp)
                    want = row_exp;
                pending_results.push_back(want);
            end
        end
    end

    // ------------------------------------------------------------------
    // Driving: everything changes on the falling edge
    // ------------------------------------------------------------------

    // Mostly back to back, some short gaps, the odd long one
    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Result side: hold tready low for random stretches
    initial
    begin : sink
        int hold;
        hold          = 0;
        m_axis_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                m_axis_tready <= 1'b0;
                hold--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                hold = pick_gap(calm);
            end
        end
    end

    // Offer one item after a random gap and hold it until accepted.
    // Entered and left at a falling edge; tvalid is left high for a following item.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [SCORE_W-1:0] score,
                             input logic is_priv, input logic listed, input logic server,
                             input logic has_exp, input policy_result_t want);
        int gap;
        gap = pick_gap(calm);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        row_has_exp   = has_exp;
        row_exp       = want;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, server, listed, is_priv, score};
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Drive one register write; the caller drops the write enable after the last one
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
    endtask

    // Every item yields one result, so an empty queue means the block is idle
    task automatic wait_idle;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    function automatic stim_row_t item_row(logic [OP_W-1:0] op, logic [SCORE_W-1:0] score,
                                           logic is_priv, logic listed, logic server);
        stim_row_t r;
        r         = '0;
        r.op      = op;
        r.score   = score;
        r.is_priv = is_priv;
        r.listed  = listed;
        r.server  = server;
        return r;
    endfunction

    function automatic stim_row_t reg_row(logic [CFG_ADDR_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] val);
        stim_row_t r;
        r          = '0;
        r.is_write = 1'b1;
        r.reg_idx  = idx;
        r.reg_val  = val;
        return r;
    endfunction

    // Attach a hand-typed result: score, goes_priv, removed, too_many, threshold, counts
    function automatic stim_row_t checked(stim_row_t r, logic [7:0] s, logic gp, logic rm,
                                          logic tm, logic [7:0] th, int unsigned u,
                                          int unsigned p);
        r.has_exp           = 1'b1;
        r.want.new_score    = s;
        r.want.goes_priv    = gp;
        r.want.was_removed  = rm;
        r.want.too_many     = tm;
        r.want.threshold    = th;
        r.want.unused_total = CB'(u);
        r.want.priv_total   = CB'(p);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        stim_row_t          directed [$];
        settings_t          plan;
        logic [OP_W-1:0]    op;
        logic [SCORE_W-1:0] score;
        int                 pick;
        int                 near;

        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        row_has_exp   = 1'b0;
        row_exp       = '0;
        calm          = 1'b0;
        errors        = 0;

        // Directed table, starting from the reset settings:
        // LFRU mode, cap 255, restart 1, window 256, ratio 85, floor 100.
        // Removes at empty counts: a listed entry leaves, the counts stay at zero
        directed.push_back(checked(item_row(OP_REMOVE, 8'd0, 0, 0, 0), 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(checked(item_row(OP_REMOVE, 8'd255, 1, 1, 0), 255, 0, 1, 0, 0, 0, 0));
        // top score is held at the cap and promoted, threshold jumps to it
        directed.push_back(checked(item_row(OP_ADD, 8'd255, 0, 0, 0), 255, 1, 0, 0, 255, 1, 1));
        directed.push_back(checked(item_row(OP_ADD, 8'd0, 0, 0, 0), 1, 0, 0, 0, 255, 2, 1));
        // a privileged add stays privileged and leaves the threshold alone
        directed.push_back(checked(item_row(OP_ADD, 8'd254, 1, 0, 0), 255, 1, 0, 0, 255, 3, 2));
        // demote: off the privileged list, back on the normal one, score quartered
        directed.push_back(checked(item_row(OP_DEMOTE, 8'd255, 1, 1, 0), 63, 0, 1, 0, 255, 3, 1));
        // server-side demote and the spare opcode pass the entry through
        directed.push_back(checked(item_row(OP_DEMOTE, 8'd200, 1, 1, 1), 200, 1, 0, 0, 255, 3, 1));
        directed.push_back(checked(item_row(OP_NOP, 8'd77, 1, 0, 0), 77, 1, 0, 0, 255, 3, 1));
        directed.push_back(checked(item_row(OP_NOP, 8'd0, 0, 1, 1), 0, 0, 0, 0, 255, 3, 1));
        directed.push_back(checked(item_row(OP_DEMOTE, 8'd3, 0, 0, 0), 0, 0, 0, 0, 255, 4, 1));
        // plain LRU: add keeps its score, demote does nothing, remove only lowers unused
        directed.push_back(reg_row(REG_POLICY_MODE, 20'd0));
        directed.push_back(checked(item_row(OP_ADD, 8'd100, 1, 0, 0), 100, 0, 0, 0, 255, 5, 1));
        directed.push_back(checked(item_row(OP_DEMOTE, 8'd9, 1, 1, 0), 9, 1, 0, 0, 255, 5, 1));
        directed.push_back(checked(item_row(OP_REMOVE, 8'd40, 1, 1, 0), 40, 0, 1, 0, 255, 4, 1));
        // zero floor and zero ratio: the privileged list is always too large
        directed.push_back(reg_row(REG_POLICY_MODE, 20'd1));
        directed.push_back(reg_row(REG_PRIV_FLOOR, 20'd0));
        directed.push_back(reg_row(REG_PRIV_RATIO, 20'd0));
        directed.push_back(checked(item_row(OP_ADD, 8'd10, 0, 0, 0), 11, 0, 0, 1, 255, 5, 1));
        // zero cap: every score collapses to zero and sits at the cap
        directed.push_back(reg_row(REG_SCORE_CAP, 20'd0));
        directed.push_back(checked(item_row(OP_ADD, 8'd50, 0, 0, 0), 0, 1, 0, 1, 0, 6, 2));
        // ratio beyond 256, top floor, one-item window and zero restart
        directed.push_back(reg_row(REG_SCORE_CAP, 20'd255));
        directed.push_back(reg_row(REG_PRIV_RATIO, 20'd511));
        directed.push_back(reg_row(REG_PRIV_FLOOR, 20'hFFFFF));
        directed.push_back(reg_row(REG_WINDOW_SIZE, 20'd1));
        directed.push_back(reg_row(REG_MIN_THRESHOLD, 20'd0));
        directed.push_back(item_row(OP_ADD, 8'd0, 0, 0, 0));
        directed.push_back(item_row(OP_ADD, 8'd0, 0, 0, 0));
        directed.push_back(item_row(OP_ADD, 8'd1, 1, 1, 1));
        // zero window: only a wrap of the window count can hit the window tests, and the full-window test wins
        directed.push_back(reg_row(REG_WINDOW_SIZE, 20'd0));
        directed.push_back(reg_row(REG_MIN_THRESHOLD, 20'd255));
        directed.push_back(item_row(OP_ADD, 8'd128, 0, 0, 0));
        directed.push_back(item_row(OP_ADD, 8'd0, 0, 0, 0));
        directed.push_back(item_row(OP_DEMOTE, 8'd255, 0, 1, 0));
        directed.push_back(item_row(OP_REMOVE, 8'd128, 0, 1, 1));

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i])
        begin
            if (directed[i].is_write)
            begin
                // drain before the first write of a group
                if (i == 0 || !directed[i-1].is_write)
                begin
                    s_axis_tvalid <= 1'b0;
                    wait_idle();
                end
                write_reg(directed[i].reg_idx, directed[i].reg_val);
                if (i == directed.size() - 1 || !directed[i+1].is_write)
                    cfg_wr_en <= 1'b0;
            end
            else
            begin
                send_item(directed[i].op, directed[i].score, directed[i].is_priv,
                          directed[i].listed, directed[i].server,
                          directed[i].has_exp, directed[i].want);
            end
        end

        // Random phases, each under its own settings; small windows keep the
        // threshold moving, the rest cover the register extremes
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       plan = '{1'b1, 8'd255, 8'd1,   16'd256,   9'd85,  20'd100};
                1:       plan = '{1'b1, 8'd20,  8'd0,   16'd8,     9'd128, 20'd0};
                2:       plan = '{1'b0, 8'd255, 8'd255, 16'd1,     9'd256, 20'd5};
                3:       plan = '{1'b1, 8'd1,   8'd255, 16'd2,     9'd0,   20'd0};
                4:       plan = '{1'b1, 8'd255, 8'd0,   16'd0,     9'd511, 20'hFFFFF};
                5:       plan = '{1'b1, 8'd100, 8'd50,  16'd65535, 9'd300, 20'd3};
                6:       plan = '{1'b1, 8'd255, 8'd10,  16'd16,    9'd64,  20'd20};
                default: plan = '{1'($urandom_range(0, 1)), 8'($urandom_range(1, 255)),
                                  8'($urandom_range(0, 255)), 16'($urandom_range(1, 40)),
                                  9'($urandom_range(0, 256)), 20'($urandom_range(0, 60))};
            endcase

            // settle the block before touching the registers
            s_axis_tvalid <= 1'b0;
            wait_idle();
            calm = (ph % 3 == 1);
            write_reg(REG_POLICY_MODE,   20'(plan.mode));
            write_reg(REG_SCORE_CAP,     20'(plan.cap));
            write_reg(REG_MIN_THRESHOLD, 20'(plan.min_thr));
            write_reg(REG_WINDOW_SIZE,   20'(plan.win));
            write_reg(REG_PRIV_RATIO,    20'(plan.ratio));
            write_reg(REG_PRIV_FLOOR,    plan.floor_val);
            cfg_wr_en <= 1'b0;

            repeat (ITEMS_PER_PHASE)
            begin
                pick = $urandom_range(0, 99);
                op   = (pick < 50) ? OP_ADD : (pick < 75) ? OP_REMOVE : OP_DEMOTE;
                // bias scores towards the extremes and the live threshold and cap
                case ($urandom_range(0, 9))
                    0:       score = 8'd0;
                    1:       score = 8'd255;
                    2, 3:
                    begin
                        near  = int'(thr) + $urandom_range(0, 4) - 2;
                        score = (near < 0) ? 8'd0 : (near > 255) ? 8'd255 : 8'(near);
                    end
                    4:       score = cap_cfg - 8'($urandom_range(0, 1));
                    default: score = 8'($urandom_range(0, 255));
                endcase
                send_item(op, score, $urandom_range(0, 2) == 0, $urandom_range(0, 3) != 0,
                          $urandom_range(0, 4) == 0, 1'b0, '0);
            end
        end

        // drain, then give any stray result time to show up
        s_axis_tvalid <= 1'b0;
        wait_idle();
        repeat (10) @(negedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
